// ===== hdl/cmrr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmrr_pkg
// Shared types and codes of the CAN message rule router: item commands,
// result kinds, the stored rule layout and the controller/datapath links.
// ----------------------------------------------------------------------------
package cmrr_pkg;

  // item commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_ROUTE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACTION  = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // command status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // configuration register indexes
  localparam logic CFG_HOST_BUS     = 1'b0;
  localparam logic CFG_WILDCARD_BUS = 1'b1;

  // configuration reset values
  localparam logic [3:0] HOST_BUS_RESET     = 4'd6;
  localparam logic [3:0] WILDCARD_BUS_RESET = 4'd15;

  // one stored rule
  typedef struct packed {
    logic        to_isotp;
    logic        to_host;
    logic [3:0]  dst_bus;
    logic [3:0]  src_bus;
    logic [31:0] id_mask;
    logic [31:0] id_value;
  } rule_t;

  // controller to datapath commands
  typedef struct packed {
    logic table_clear;
    logic table_add;
    logic latch_msg;
    logic walk_step;
    logic load_action;
    logic load_summary;
    logic load_status;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rule_hit;
    logic walk_end;
    logic table_empty;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/cmrr_ram.sv =====
// ----------------------------------------------------------------------------
// cmrr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cmrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cmrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmrr_ctrl
// Controller of the rule router: takes items, sequences the rule walk and
// schedules action, summary and status results into the output register.
// ----------------------------------------------------------------------------
module cmrr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  cmrr_pkg::dp_status_t  status_i,
  output cmrr_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SUMMARY,
    S_STATUS
  } state_e;

  state_e state_q, state_d;

  // items are taken only between walks
  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (command_i)
            cmrr_pkg::CMD_CLEAR: begin
              cmd_o.table_clear = 1'b1;
              state_d           = S_STATUS;
            end
            cmrr_pkg::CMD_ADD: begin
              cmd_o.table_add = 1'b1;
              state_d         = S_STATUS;
            end
            cmrr_pkg::CMD_ROUTE: begin
              cmd_o.latch_msg = 1'b1;
              state_d         = status_i.table_empty ? S_SUMMARY : S_WALK;
            end
            default: begin
              // unused command: dropped without a result
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        // a hit waits for room in the output register, a miss moves on
        if (!status_i.rule_hit || status_i.out_free) begin
          cmd_o.load_action = status_i.rule_hit;
          if (status_i.walk_end) begin
            state_d = S_SUMMARY;
          end else begin
            cmd_o.walk_step = 1'b1;
          end
        end
      end
      S_SUMMARY: begin
        if (status_i.out_free) begin
          cmd_o.load_summary = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_STATUS: begin
        if (status_i.out_free) begin
          cmd_o.load_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/cmrr_dp.sv =====
// ----------------------------------------------------------------------------
// cmrr_dp
// Datapath of the rule router: configuration registers, rule table and fill
// count, walk index, rule match logic, traffic counters and output register.
// ----------------------------------------------------------------------------
module cmrr_dp #(
  parameter int MAX_RULES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [3:0]           cfg_data_i,
  // input item fields
  input  logic [3:0]           bus_i,
  input  logic [31:0]          id_value_i,
  input  logic [31:0]          id_mask_i,
  input  logic [3:0]           dst_bus_i,
  input  logic                 to_host_i,
  input  logic                 to_isotp_i,
  input  logic                 is_can_i,
  // control
  input  cmrr_pkg::ctrl_cmd_t  cmd_i,
  output cmrr_pkg::dp_status_t status_o,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [3:0]           rule_index_o,
  output logic [3:0]           out_bus_o,
  output logic                 send_on_bus_o,
  output logic                 send_to_host_o,
  output logic                 send_to_isotp_o,
  output logic                 dispatched_o,
  output logic                 result_status_o,
  output logic [31:0]          routed_count_o,
  output logic [31:0]          dropped_count_o,
  output logic                 last_o
);

  localparam int AddrW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CountW = $clog2(MAX_RULES + 1);
  localparam int RuleW  = $bits(cmrr_pkg::rule_t);

  logic [3:0]        host_bus_q;
  logic [3:0]        wild_bus_q;
  logic [CountW-1:0] count_q;
  logic [AddrW-1:0]  idx_q;
  logic [AddrW-1:0]  idx_d;
  logic [AddrW-1:0]  raddr;
  logic [3:0]        msg_bus_q;
  logic [31:0]       msg_id_q;
  logic              msg_can_q;
  logic              disp_q;
  logic              cmd_status_q;
  logic [31:0]       routed_q;
  logic [31:0]       dropped_q;
  logic [31:0]       routed_d;
  logic [31:0]       dropped_d;
  logic              table_full;
  cmrr_pkg::rule_t   wr_rule;
  cmrr_pkg::rule_t   rd_rule;
  logic [RuleW-1:0]  rd_data;
  logic              src_ok;
  logic              id_ok;
  logic              on_bus;

  // output register
  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [3:0]        rule_index_q;
  logic [3:0]        out_bus_q;
  logic              send_on_bus_q;
  logic              send_to_host_q;
  logic              send_to_isotp_q;
  logic              dispatched_q;
  logic              status_q;
  logic [31:0]       routed_count_q;
  logic [31:0]       dropped_count_q;
  logic              last_q;
  logic              out_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_bus_q <= cmrr_pkg::HOST_BUS_RESET;
      wild_bus_q <= cmrr_pkg::WILDCARD_BUS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cmrr_pkg::CFG_HOST_BUS:     host_bus_q <= cfg_data_i;
        cmrr_pkg::CFG_WILDCARD_BUS: wild_bus_q <= cfg_data_i;
        default:                    host_bus_q <= host_bus_q;
      endcase
    end
  end

  // rule table
  assign table_full       = (count_q >= CountW'(MAX_RULES));
  assign wr_rule.to_isotp = to_isotp_i;
  assign wr_rule.to_host  = to_host_i;
  assign wr_rule.dst_bus  = dst_bus_i;
  assign wr_rule.src_bus  = bus_i;
  assign wr_rule.id_mask  = id_mask_i;
  assign wr_rule.id_value = id_value_i;

  cmrr_ram #(
    .WIDTH (RuleW),
    .DEPTH (MAX_RULES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.table_add && !table_full),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wr_rule),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign rd_rule = cmrr_pkg::rule_t'(rd_data);

  // walk index and table read address
  always_comb begin
    priority if (cmd_i.latch_msg) begin
      idx_d = '0;
    end else if (cmd_i.walk_step) begin
      idx_d = idx_q + AddrW'(1);
    end else begin
      idx_d = idx_q;
    end
  end
  assign raddr = idx_d;

  // fill count, walk index, command status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      cmd_status_q <= cmrr_pkg::STATUS_OK;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.table_clear) begin
        count_q      <= '0;
        cmd_status_q <= cmrr_pkg::STATUS_OK;
      end else if (cmd_i.table_add) begin
        if (table_full) begin
          cmd_status_q <= cmrr_pkg::STATUS_FULL;
        end else begin
          count_q      <= count_q + CountW'(1);
          cmd_status_q <= cmrr_pkg::STATUS_OK;
        end
      end
    end
  end

  // message held for the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_msg) begin
      msg_bus_q <= bus_i;
      msg_id_q  <= id_value_i;
      msg_can_q <= is_can_i;
    end
  end

  // rule match against the held message
  assign src_ok = (rd_rule.src_bus == wild_bus_q) || (rd_rule.src_bus == msg_bus_q);
  assign id_ok  = (rd_rule.id_mask == '0) || !msg_can_q ||
                  ((msg_id_q & rd_rule.id_mask) == rd_rule.id_value);
  assign on_bus = (rd_rule.dst_bus < host_bus_q);

  // dispatched flag and traffic counters
  assign routed_d  = disp_q ? routed_q + 32'd1 : routed_q;
  assign dropped_d = disp_q ? dropped_q : dropped_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q    <= 1'b0;
      routed_q  <= '0;
      dropped_q <= '0;
    end else begin
      if (cmd_i.latch_msg) begin
        disp_q <= 1'b0;
      end else if (cmd_i.load_action) begin
        disp_q <= 1'b1;
      end
      if (cmd_i.load_summary) begin
        routed_q  <= routed_d;
        dropped_q <= dropped_d;
      end
    end
  end

  // status to the controller
  assign status_o.rule_hit    = src_ok && id_ok;
  assign status_o.walk_end    = ((CountW'(idx_q) + CountW'(1)) == count_q);
  assign status_o.table_empty = (count_q == '0);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // output register valid
  assign out_load = cmd_i.load_action || cmd_i.load_summary || cmd_i.load_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q          <= cmrr_pkg::KIND_STATUS;
      rule_index_q    <= '0;
      out_bus_q       <= '0;
      send_on_bus_q   <= 1'b0;
      send_to_host_q  <= 1'b0;
      send_to_isotp_q <= 1'b0;
      dispatched_q    <= 1'b0;
      status_q        <= cmrr_pkg::STATUS_OK;
      routed_count_q  <= '0;
      dropped_count_q <= '0;
      last_q          <= 1'b1;
      priority if (cmd_i.load_action) begin
        kind_q          <= cmrr_pkg::KIND_ACTION;
        rule_index_q    <= 4'(idx_q);
        out_bus_q       <= on_bus ? rd_rule.dst_bus : 4'd0;
        send_on_bus_q   <= on_bus;
        send_to_host_q  <= rd_rule.to_host;
        send_to_isotp_q <= rd_rule.to_isotp;
        last_q          <= 1'b0;
      end else if (cmd_i.load_summary) begin
        kind_q          <= cmrr_pkg::KIND_SUMMARY;
        dispatched_q    <= disp_q;
        routed_count_q  <= routed_d;
        dropped_count_q <= dropped_d;
      end else begin
        status_q        <= cmd_status_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign rule_index_o    = rule_index_q;
  assign out_bus_o       = out_bus_q;
  assign send_on_bus_o   = send_on_bus_q;
  assign send_to_host_o  = send_to_host_q;
  assign send_to_isotp_o = send_to_isotp_q;
  assign dispatched_o    = dispatched_q;
  assign result_status_o = status_q;
  assign routed_count_o  = routed_count_q;
  assign dropped_count_o = dropped_count_q;
  assign last_o          = last_q;

endmodule

// ===== hdl/can_message_rule_router.sv =====
// ----------------------------------------------------------------------------
// can_message_rule_router
// Routing rule table for CAN messages: clear, add and route items; route
// walks the stored rules in order, giving one action per matching rule and
// a closing summary with the routed and dropped counters.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o    command, bus, id, mask, rule fields
//  out       output     out_valid_o / out_stall_i  one result item per transfer
//  cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
//  clear and add: the item is taken, then it gets a status result
//  route: the item is taken, then one walk step per stored rule (one table read
//  each; a hit waits for room in the output register), then the summary, also for an empty table
//  a new item is taken once the previous item's last result is in the output
//  register; a stalled output holds the walk at the next matching rule
//  reset clears the table fill count and counters and sets the configuration to its reset values at once
// ----------------------------------------------------------------------------
module can_message_rule_router #(
  parameter int MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  bus_i,
  input  logic [31:0] id_value_i,
  input  logic [31:0] id_mask_i,
  input  logic [3:0]  dst_bus_i,
  input  logic        to_host_i,
  input  logic        to_isotp_i,
  input  logic        is_can_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  rule_index_o,
  output logic [3:0]  out_bus_o,
  output logic        send_on_bus_o,
  output logic        send_to_host_o,
  output logic        send_to_isotp_o,
  output logic        dispatched_o,
  output logic        status_o,
  output logic [31:0] routed_count_o,
  output logic [31:0] dropped_count_o,
  output logic        last_o
);

  cmrr_pkg::ctrl_cmd_t  cmd;
  cmrr_pkg::dp_status_t dp_status;

  // controller
  cmrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // datapath
  cmrr_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .bus_i           (bus_i),
    .id_value_i      (id_value_i),
    .id_mask_i       (id_mask_i),
    .dst_bus_i       (dst_bus_i),
    .to_host_i       (to_host_i),
    .to_isotp_i      (to_isotp_i),
    .is_can_i        (is_can_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .rule_index_o    (rule_index_o),
    .out_bus_o       (out_bus_o),
    .send_on_bus_o   (send_on_bus_o),
    .send_to_host_o  (send_to_host_o),
    .send_to_isotp_o (send_to_isotp_o),
    .dispatched_o    (dispatched_o),
    .result_status_o (status_o),
    .routed_count_o  (routed_count_o),
    .dropped_count_o (dropped_count_o),
    .last_o          (last_o)
  );

endmodule

// ===== hdl/cmrr_checker.sv =====
// ----------------------------------------------------------------------------
// cmrr_checker
// Port level checks of the rule router's result stream, bound to the top.
// ----------------------------------------------------------------------------
module cmrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [3:0]  out_bus_o,
  input logic        send_on_bus_o,
  input logic        status_o,
  input logic        last_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a summary always closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == cmrr_pkg::KIND_SUMMARY |-> last_o)
    else $error("summary without last");

  // an action is never the final result of a route
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == cmrr_pkg::KIND_ACTION |-> !last_o)
    else $error("action marked last");

  // bus code only shown with a bus forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_on_bus_o |-> out_bus_o == 4'd0)
    else $error("out bus set without bus forward");

  // table full only reported on status results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> kind_o == cmrr_pkg::KIND_STATUS)
    else $error("status flag on non status result");

endmodule

bind can_message_rule_router cmrr_checker u_cmrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .out_bus_o     (out_bus_o),
  .send_on_bus_o (send_on_bus_o),
  .status_o      (status_o),
  .last_o        (last_o)
);
